// ----- rtl/tfn_pkg.sv -----
package tfn_pkg;

    localparam int COORD_W  = 24;
    localparam int EDGE_W   = COORD_W + 1;
    localparam int CROSS_W  = 2 * EDGE_W;
    localparam int MAG_W    = 30;
    localparam int MUL_W    = MAG_W + 1;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SUM_W    = 2 * MAG_W + 2;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int NFB      = 14;
    localparam int QUO_W    = NFB + 1;
    localparam int DIV_W    = MAG_W + NFB + 1;
    localparam int NRM_W    = 16;
    // also has to count the seven multiply steps
    localparam int STEP_W   = $clog2(QUO_W + 1);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [EDGE_W-1:0]  t_edge;
    typedef logic signed [NRM_W-1:0]   t_nrm;

    typedef struct packed {
        t_edge e1x;
        t_edge e1y;
        t_edge e1z;
        t_edge e2x;
        t_edge e2y;
        t_edge e2z;
        logic  last;
    } t_tri;

endpackage

// ----- rtl/tfn_if.sv -----
interface tfn_vertex_if import tfn_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord x_coord;
    t_coord y_coord;
    t_coord z_coord;
    logic   end_of_mesh;

    modport source (output valid, x_coord, y_coord, z_coord, end_of_mesh, input ready);
    modport sink (input valid, x_coord, y_coord, z_coord, end_of_mesh, output ready);
endinterface

interface tfn_normal_if import tfn_pkg::*; ();
    logic valid;
    logic ready;
    t_nrm normal_x;
    t_nrm normal_y;
    t_nrm normal_z;
    logic degenerate;
    logic last_triangle;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate, last_triangle,
                    input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, degenerate, last_triangle,
                  output ready);
endinterface

// ----- rtl/tfn_front.sv -----
module tfn_front import tfn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tfn_vertex_if.sink  i_vertex,
    output logic        o_tri_valid,
    input  logic        i_tri_ready,
    output t_tri        o_tri
);

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    logic [1:0] r_phase;
    t_coord     r_v0 [3];
    t_coord     r_v1 [3];
    logic       accept;

    assign i_vertex.ready = (r_phase != PH_THIRD) || i_tri_ready;
    assign accept         = i_vertex.valid && i_vertex.ready;
    assign o_tri_valid    = i_vertex.valid && (r_phase == PH_THIRD);

    assign o_tri.e1x  = EDGE_W'(r_v1[0]) - EDGE_W'(r_v0[0]);
    assign o_tri.e1y  = EDGE_W'(r_v1[1]) - EDGE_W'(r_v0[1]);
    assign o_tri.e1z  = EDGE_W'(r_v1[2]) - EDGE_W'(r_v0[2]);
    assign o_tri.e2x  = EDGE_W'(i_vertex.x_coord) - EDGE_W'(r_v0[0]);
    assign o_tri.e2y  = EDGE_W'(i_vertex.y_coord) - EDGE_W'(r_v0[1]);
    assign o_tri.e2z  = EDGE_W'(i_vertex.z_coord) - EDGE_W'(r_v0[2]);
    assign o_tri.last = i_vertex.end_of_mesh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
        end else if (accept) begin
            case (r_phase)
                PH_THIRD: begin
                    r_phase <= PH_FIRST;
                end
                PH_SECOND: begin
                    // partial triangle at end of mesh is dropped
                    if (i_vertex.end_of_mesh) begin
                        r_phase <= PH_FIRST;
                    end else begin
                        r_phase <= PH_THIRD;
                        r_v1[0] <= i_vertex.x_coord;
                        r_v1[1] <= i_vertex.y_coord;
                        r_v1[2] <= i_vertex.z_coord;
                    end
                end
                default: begin
                    if (i_vertex.end_of_mesh) begin
                        r_phase <= PH_FIRST;
                    end else begin
                        r_phase <= PH_SECOND;
                        r_v0[0] <= i_vertex.x_coord;
                        r_v0[1] <= i_vertex.y_coord;
                        r_v0[2] <= i_vertex.z_coord;
                    end
                end
            endcase
        end
    end

endmodule

// ----- rtl/tfn_queue.sv -----
module tfn_queue import tfn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_tri i_push_tri,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_tri o_pop_tri
);

    t_tri       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_tri    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_tri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/tfn_back.sv -----
module tfn_back import tfn_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_tri_valid,
    output logic         o_tri_ready,
    input  t_tri         i_tri,
    tfn_normal_if.source o_normal
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_MAG  = 3'd2;
    localparam logic [2:0] S_NORM = 3'd3;
    localparam logic [2:0] S_SQR  = 3'd4;
    localparam logic [2:0] S_SQRT = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic [SUM_W-1:0] SQ_TOP = SUM_W'(1) << (SUM_W - 2);

    logic [2:0]                r_state;
    logic [STEP_W-1:0]         r_step;
    logic [1:0]                r_comp;
    t_edge                     r_e1 [3];
    t_edge                     r_e2 [3];
    logic                      r_last;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [CROSS_W-1:0] r_cross [3];
    logic [CROSS_W-1:0]        r_mag [3];
    logic                      r_neg [3];
    logic [SUM_W-1:0]          r_sum;
    logic [SUM_W-1:0]          r_res;
    logic [SUM_W-1:0]          r_bit;
    logic [ROOT_W-1:0]         r_root;
    logic [ROOT_W-1:0]         r_rem;
    logic [QUO_W-1:0]          r_dlo;
    logic [QUO_W-1:0]          r_q;
    t_nrm                      r_nrm [3];
    logic                      r_degen;
    logic                      r_out_valid;
    t_nrm                      r_out_x;
    t_nrm                      r_out_y;
    t_nrm                      r_out_z;
    logic                      r_out_degen;
    logic                      r_out_last;

    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic [STEP_W-1:0]         pair;
    logic [1:0]                acc_comp;
    logic                      any_high;
    logic                      all_low;
    logic [SUM_W-1:0]          sq_trial;
    logic                      sq_ge;
    logic [SUM_W-1:0]          sq_res_next;
    logic [DIV_W-1:0]          div_num;
    logic [ROOT_W:0]           div_trial;
    logic                      div_ge;
    logic [QUO_W-1:0]          q_next;
    t_nrm                      q_ext;
    logic                      out_free;

    assign o_tri_ready = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_normal.ready;

    // shared multiplier: cross terms first, then squares of the scaled magnitudes
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_MUL) begin
            case (r_step)
                STEP_W'(0): begin mul_a = MUL_W'(r_e1[1]); mul_b = MUL_W'(r_e2[2]); end
                STEP_W'(1): begin mul_a = MUL_W'(r_e1[2]); mul_b = MUL_W'(r_e2[1]); end
                STEP_W'(2): begin mul_a = MUL_W'(r_e1[2]); mul_b = MUL_W'(r_e2[0]); end
                STEP_W'(3): begin mul_a = MUL_W'(r_e1[0]); mul_b = MUL_W'(r_e2[2]); end
                STEP_W'(4): begin mul_a = MUL_W'(r_e1[0]); mul_b = MUL_W'(r_e2[1]); end
                STEP_W'(5): begin mul_a = MUL_W'(r_e1[1]); mul_b = MUL_W'(r_e2[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == S_SQR) begin
            case (r_step)
                STEP_W'(0): mul_a = $signed({1'b0, r_mag[0][MAG_W-1:0]});
                STEP_W'(1): mul_a = $signed({1'b0, r_mag[1][MAG_W-1:0]});
                STEP_W'(2): mul_a = $signed({1'b0, r_mag[2][MAG_W-1:0]});
                default:    mul_a = '0;
            endcase
            mul_b = mul_a;
        end
    end

    assign pair     = r_step - STEP_W'(1);
    assign acc_comp = pair[2:1];

    always_comb begin
        any_high = 1'b0;
        all_low  = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (r_mag[k][CROSS_W-1:MAG_W] != '0) begin
                any_high = 1'b1;
            end
            if (r_mag[k][MAG_W-1]) begin
                all_low = 1'b0;
            end
        end
    end

    // one result bit of the square root per cycle
    assign sq_trial    = r_res + r_bit;
    assign sq_ge       = (r_sum >= sq_trial);
    assign sq_res_next = sq_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    // restoring division, one quotient bit per cycle, rounding folded into the dividend
    assign div_num   = DIV_W'({r_mag[r_comp][MAG_W-1:0], NFB'(0)})
                     + DIV_W'(r_root >> 1);
    assign div_trial = {r_rem, r_dlo[QUO_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_root});
    assign q_next    = {r_q[QUO_W-2:0], div_ge};
    assign q_ext     = NRM_W'(q_next);

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_normal.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_tri_valid) begin
                        r_e1[0] <= i_tri.e1x;
                        r_e1[1] <= i_tri.e1y;
                        r_e1[2] <= i_tri.e1z;
                        r_e2[0] <= i_tri.e2x;
                        r_e2[1] <= i_tri.e2y;
                        r_e2[2] <= i_tri.e2z;
                        r_last  <= i_tri.last;
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_step != '0) begin
                        if (!pair[0]) begin
                            r_cross[acc_comp] <= CROSS_W'(r_prod);
                        end else begin
                            r_cross[acc_comp] <= r_cross[acc_comp] - CROSS_W'(r_prod);
                        end
                    end
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(6)) begin
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    for (int k = 0; k < 3; k++) begin
                        r_neg[k] <= r_cross[k][CROSS_W-1];
                        r_mag[k] <= r_cross[k][CROSS_W-1] ? CROSS_W'(-r_cross[k])
                                                          : CROSS_W'(r_cross[k]);
                        r_nrm[k] <= '0;
                    end
                    if (r_cross[0] == '0 && r_cross[1] == '0 && r_cross[2] == '0) begin
                        r_degen <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_degen <= 1'b0;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    // bring the largest magnitude into the top bit of the scaled field
                    if (any_high) begin
                        for (int k = 0; k < 3; k++) begin
                            r_mag[k] <= r_mag[k] >> 1;
                        end
                    end else if (all_low) begin
                        for (int k = 0; k < 3; k++) begin
                            r_mag[k] <= r_mag[k] << 1;
                        end
                    end else begin
                        r_sum   <= '0;
                        r_step  <= '0;
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(0)) begin
                        r_sum <= '0;
                    end else begin
                        r_sum <= r_sum + SUM_W'(r_prod);
                    end
                    if (r_step == STEP_W'(3)) begin
                        r_res   <= '0;
                        r_bit   <= SQ_TOP;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sq_ge) begin
                        r_sum <= r_sum - sq_trial;
                    end
                    r_res <= sq_res_next;
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_root  <= ROOT_W'(sq_res_next);
                        r_comp  <= 2'd0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_step == '0) begin
                        r_rem  <= ROOT_W'(div_num[DIV_W-1:QUO_W]);
                        r_dlo  <= div_num[QUO_W-1:0];
                        r_q    <= '0;
                        r_step <= STEP_W'(1);
                    end else begin
                        r_rem  <= div_ge ? ROOT_W'(div_trial - {1'b0, r_root})
                                         : ROOT_W'(div_trial);
                        r_dlo  <= r_dlo << 1;
                        r_q    <= q_next;
                        if (r_step == STEP_W'(QUO_W)) begin
                            r_nrm[r_comp] <= r_neg[r_comp] ? -q_ext : q_ext;
                            r_step        <= '0;
                            if (r_comp == 2'd2) begin
                                r_state <= S_DONE;
                            end else begin
                                r_comp <= r_comp + 2'd1;
                            end
                        end else begin
                            r_step <= r_step + STEP_W'(1);
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= r_nrm[0];
                        r_out_y     <= r_nrm[1];
                        r_out_z     <= r_nrm[2];
                        r_out_degen <= r_degen;
                        r_out_last  <= r_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_normal.valid         = r_out_valid;
    assign o_normal.normal_x      = r_out_x;
    assign o_normal.normal_y      = r_out_y;
    assign o_normal.normal_z      = r_out_z;
    assign o_normal.degenerate    = r_out_degen;
    assign o_normal.last_triangle = r_out_last;

endmodule

// ----- rtl/triangle_face_normal_core.sv -----
// triangle face normal core
// i_vertex carries one vertex per item (x, y, z in signed 24-bit fixed point with
// 16 fraction bits, plus end_of_mesh). every third vertex closes a triangle and
// o_normal then carries one unit normal in signed Q1.14 with degenerate and
// last_triangle flags. a zero cross product gives a zero normal with degenerate set.
// end_of_mesh on the first or second vertex of a triangle drops that partial triangle
// and gives no item on o_normal.
// the first two vertices of a triangle are taken one per cycle. the third vertex goes
// as a pair of edges into a two-entry queue, so vertices keep flowing while the
// normal unit is busy. the normal unit shares one multiplier and runs a bit-serial
// square root and divider: it accepts a triangle, forms the cross products, takes
// magnitudes, scales them, sums squares, takes the root, runs three divisions and
// loads the output (a degenerate triangle skips from magnitudes to the output); it
// takes no new triangle until it is through with the last, so that unit sets the rate.
// a finished normal waits in an output register; while o_normal is stalled the unit
// holds its result and the queue fills, and then i_vertex.ready drops on third
// vertices. reset (synchronous, active low) empties the queue and output register and
// restarts triangle grouping at the first vertex.
module triangle_face_normal_core import tfn_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tfn_vertex_if.sink   i_vertex,
    tfn_normal_if.source o_normal
);

    logic push_valid;
    logic push_ready;
    t_tri push_tri;
    logic pop_valid;
    logic pop_ready;
    t_tri pop_tri;

    tfn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vertex    (i_vertex),
        .o_tri_valid (push_valid),
        .i_tri_ready (push_ready),
        .o_tri       (push_tri)
    );

    tfn_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_tri   (push_tri),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_tri    (pop_tri)
    );

    tfn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tri_valid (pop_valid),
        .o_tri_ready (pop_ready),
        .i_tri       (pop_tri),
        .o_normal    (o_normal)
    );

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_normal.valid && o_normal.degenerate |->
            o_normal.normal_x == '0 && o_normal.normal_y == '0 && o_normal.normal_z == '0)
        else $error("degenerate normal is not zero");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_normal.valid |->
            o_normal.normal_x <= 16'sd16384 && o_normal.normal_x >= -16'sd16384 &&
            o_normal.normal_y <= 16'sd16384 && o_normal.normal_y >= -16'sd16384 &&
            o_normal.normal_z <= 16'sd16384 && o_normal.normal_z >= -16'sd16384)
        else $error("normal component out of unit range");

    a_nonzero_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_normal.valid && !o_normal.degenerate |->
            o_normal.normal_x != '0 || o_normal.normal_y != '0 || o_normal.normal_z != '0)
        else $error("non-degenerate triangle gave zero normal");

    a_pop_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_valid && pop_ready |=> !pop_ready)
        else $error("normal unit took a second triangle while busy");

endmodule
